// ----- rtl/gmw_pkg.sv -----
// Shared types and constants for the grayscale morphology window block.
// No dependencies.
`timescale 1ns / 1ps
package gmw_pkg;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_RADIUS = 9;
   localparam int DIM_W          = 17;
   localparam int PIX_W          = 8;
   localparam int MROW_W         = 19;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
   localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

   localparam logic [1:0] OP_MASK  = 2'd0;
   localparam logic [1:0] OP_PIXEL = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;
   localparam logic [1:0] REG_RADIUS = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_PUT   = 5'b10000
   } state_type;
endpackage

// ----- rtl/gmw_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module gmw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/grayscale_morphology_window_top.sv -----
// Top level of the grayscale erosion/dilation block.
// Depends on gmw_pkg and gmw_ram.
`timescale 1ns / 1ps
// Usage:
//   req_ channel carries mask-row loads, pixels in raster order and flush
//   requests; rsp_ channel returns one filtered pixel per ready window, with
//   rsp_frame_last on the final pixel. The user must write mode, width,
//   height and radius over csr_ only while the block is idle; the block
//   itself does not enforce it. A pixel or flush goes from idle through
//   check back to idle when it yields no result, and through check, scan,
//   drain and put when it does: every window tap is read from the line
//   store, one read per cycle through its single read port. One request
//   is in work at a time. Results lag input by r rows plus r pixels; flush
//   requests after the last pixel drain the tail of the frame.
//   Reset clears counters, sets the mask to all ones and the registers to
//   their defaults; the line store is not cleared and needs no pass.
//   A stalled receiver holds the result in the output register; the block
//   takes the next request meanwhile and waits only when a new result is
//   ready before the old one left.
module grayscale_morphology_window_top
   import gmw_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_pixel_value,
   input  logic [4:0]        req_mask_row_index,
   input  logic [18:0]       req_mask_row_bits,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_result_pixel,
   output logic              rsp_frame_last,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   localparam int TAP    = 2 * MAX_RADIUS + 1;
   localparam int RING   = 2 * MAX_RADIUS + 2;
   localparam int TW     = $clog2(TAP);
   localparam int GW     = $clog2(RING);
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int DEPTH  = RING * MAX_WIDTH;
   localparam int AW     = $clog2(DEPTH);
   localparam int YW     = DIM_W + 1;

   logic              mode_ff;
   logic [10:0]       width_ff;
   logic [15:0]       height_ff;
   logic [3:0]        radius_ff;
   logic [TAP-1:0]    mask_ff [TAP];

   logic [CW-1:0]     in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [15:0]       in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [GW-1:0]     in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   state_type         state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [TW-1:0]     t_ff, t_in, dx_ff, dx_in;
   logic signed [YW-1:0] yu_ff, yu_in, xu_ff, xu_in;
   logic [GW-1:0]     yring_ff, yring_in;
   logic              take_ff, take_in;
   logic [PIX_W-1:0]  acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [DIM_W-1:0]  eff_w, eff_h, need_row, need_col, row_r, col_r;
   logic [DIM_W-1:0]  in_col_x, in_row_x, out_col_x, out_row_x, col_p1, row_p1;
   logic [3:0]        eff_r;
   logic [TW-1:0]     span;
   logic [PIX_W-1:0]  neutral, rd_data;
   logic [CW-1:0]     x_cl;
   logic              wr_en, accept, ready_pix, emit_ok, put_go, put_last;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic signed [YW-1:0] y1, h_m1, w_m1;
   logic [GW:0]       ring_sub;

   always_comb begin
      if (width_ff == 11'd0) begin
         eff_w = DIM_W'(1);
      end else if (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) begin
         eff_w = DIM_W'(MAX_WIDTH);
      end else begin
         eff_w = DIM_W'(width_ff);
      end
      eff_h   = (height_ff == 16'd0) ? DIM_W'(1) : DIM_W'(height_ff);
      eff_r   = (radius_ff > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_ff;
      span    = TW'({eff_r, 1'b0});
      neutral = mode_ff ? PIX_MIN : PIX_MAX;
      in_col_x  = DIM_W'(in_col_ff);
      in_row_x  = DIM_W'(in_row_ff);
      out_col_x = DIM_W'(out_col_ff);
      out_row_x = DIM_W'(out_row_ff);
      row_r   = out_row_x + DIM_W'(eff_r);
      col_r   = out_col_x + DIM_W'(eff_r);
      need_row = (row_r > eff_h - DIM_W'(1)) ? eff_h - DIM_W'(1) : row_r;
      need_col = (col_r > eff_w - DIM_W'(1)) ? eff_w - DIM_W'(1) : col_r;
      ready_pix = (in_row_x > need_row) ||
                  ((in_row_x == need_row) && (in_col_x > need_col));
      h_m1 = YW'(eff_h) - YW'(1);
      w_m1 = YW'(eff_w) - YW'(1);
      if (xu_ff < 0) begin
         x_cl = '0;
      end else if (xu_ff > w_m1) begin
         x_cl = CW'(w_m1);
      end else begin
         x_cl = CW'(xu_ff);
      end
      ring_sub = {1'b0, out_ring_ff} - (GW+1)'(eff_r);
      if (ring_sub[GW]) begin
         ring_sub = ring_sub + (GW+1)'(RING);
      end
      y1 = yu_ff + YW'(1);
      col_p1 = out_col_x + DIM_W'(1);
      row_p1 = out_row_x + DIM_W'(1);
      put_last = (col_p1 >= eff_w) && (row_p1 >= eff_h);
   end

   assign accept  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign wr_en   = accept && (req_opcode == OP_PIXEL) && (in_row_x < eff_h);
   assign wr_addr = AW'(in_ring_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);
   assign rd_addr = AW'(yring_ff) * AW'(MAX_WIDTH) + AW'(x_cl);
   assign put_go  = (state_ff == ST_PUT) && (!rsp_valid_ff || rsp_ready);
   assign emit_ok = (op_ff == OP_PIXEL) ? ready_pix : (in_row_x >= eff_h);

   gmw_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_ring_in  = in_ring_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_ring_in = out_ring_ff;
      t_in        = t_ff;
      dx_in       = dx_ff;
      yu_in       = yu_ff;
      xu_in       = xu_ff;
      yring_in    = yring_ff;
      take_in     = 1'b0;
      acc_in      = acc_ff;
      rsp_pix_in  = rsp_pix_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (take_ff && (mode_ff ? (rd_data > acc_ff) : (rd_data < acc_ff))) begin
         acc_in = rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_opcode;
               if (req_opcode == OP_FLUSH) begin
                  state_in = ST_CHECK;
               end else if (wr_en) begin
                  state_in = ST_CHECK;
                  if (DIM_W'(in_col_ff) + DIM_W'(1) >= eff_w) begin
                     in_col_in = '0;
                     in_row_in = in_row_ff + 16'd1;
                     in_ring_in = (in_ring_ff == GW'(RING - 1)) ? '0 :
                                  in_ring_ff + GW'(1);
                  end else begin
                     in_col_in = in_col_ff + CW'(1);
                  end
               end
            end
         end
         ST_CHECK: begin
            if (emit_ok) begin
               state_in = ST_SCAN;
               t_in     = '0;
               dx_in    = '0;
               yu_in    = YW'(out_row_x) - YW'(eff_r);
               xu_in    = YW'(out_col_x) - YW'(eff_r);
               yring_in = (out_row_x >= DIM_W'(eff_r)) ? GW'(ring_sub) : '0;
               acc_in   = neutral;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            take_in = mask_ff[t_ff][dx_ff];
            if (dx_ff == span) begin
               dx_in = '0;
               xu_in = YW'(out_col_x) - YW'(eff_r);
               t_in  = t_ff + TW'(1);
               yu_in = y1;
               if ((y1 > 0) && (y1 <= h_m1)) begin
                  yring_in = (yring_ff == GW'(RING - 1)) ? '0 : yring_ff + GW'(1);
               end
               if (t_ff == span) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               dx_in = dx_ff + TW'(1);
               xu_in = xu_ff + YW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (put_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_pix_in   = acc_ff;
               rsp_last_in  = put_last;
               if (col_p1 >= eff_w) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 16'd1;
                  out_ring_in = (out_ring_ff == GW'(RING - 1)) ? '0 :
                                out_ring_ff + GW'(1);
               end else begin
                  out_col_in = out_col_ff + CW'(1);
               end
               if (put_last) begin
                  out_col_in  = '0;
                  out_row_in  = '0;
                  out_ring_in = '0;
                  in_col_in   = '0;
                  in_row_in   = '0;
                  in_ring_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_ring_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_ring_ff  <= '0;
         take_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b0;
         width_ff     <= 11'd1024;
         height_ff    <= 16'd1024;
         radius_ff    <= 4'd9;
         for (int i = 0; i < TAP; i++) begin
            mask_ff[i] <= '1;
         end
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_ring_ff   <= in_ring_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_ring_ff  <= out_ring_in;
         take_ff      <= take_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_MODE:   mode_ff   <= csr_wdata[0];
               REG_WIDTH:  width_ff  <= csr_wdata[10:0];
               REG_HEIGHT: height_ff <= csr_wdata;
               REG_RADIUS: radius_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (accept && (req_opcode == OP_MASK) &&
             (int'(req_mask_row_index) < TAP)) begin
            mask_ff[TW'(req_mask_row_index)] <= TAP'({12'd0, req_mask_row_bits});
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      t_ff        <= t_in;
      dx_ff       <= dx_in;
      yu_ff       <= yu_in;
      xu_ff       <= xu_in;
      yring_ff    <= yring_in;
      acc_ff      <= acc_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_pix_ff;
   assign rsp_frame_last   = rsp_last_ff;

   a_take_from_scan: assert property (@(posedge clock) disable iff (reset)
      take_ff |-> $past(state_ff == ST_SCAN))
      else $error("tap sample outside scan");
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_PUT))
      else $error("result loaded outside put");
   a_ring_range: assert property (@(posedge clock) disable iff (reset)
      (int'(in_ring_ff) < RING) && (int'(out_ring_ff) < RING))
      else $error("ring index out of range");
   a_idle_after_put: assert property (@(posedge clock) disable iff (reset)
      put_go |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("put did not publish result");
endmodule

// ----- tb/sv/grayscale_morphology_window_top_test.sv -----
// Self-checking test of grayscale_morphology_window_top: random and directed
// frames, results predicted in the bench. Depends on gmw_pkg and the block RTL.
`timescale 1ns / 1ps
module grayscale_morphology_window_top_test;
   import gmw_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int RING = 2 * DEF_MAX_RADIUS + 2;
   localparam int TAPS = 2 * DEF_MAX_RADIUS + 1;
   localparam int SETTLE = 400;
   localparam int STALL_LIMIT = 6000;

   typedef struct {
      logic [7:0] pix;
      logic       last;
   } filtered_t;

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, rsp_ready = 0, csr_we = 0;
   logic [1:0]  req_opcode = OP_PIXEL, csr_index = REG_MODE;
   logic [7:0]  req_pixel_value = 0;
   logic [4:0]  req_mask_row_index = 0;
   logic [18:0] req_mask_row_bits = 0;
   logic [15:0] csr_wdata = 0;
   logic        req_ready, rsp_valid, rsp_frame_last;
   logic [7:0]  rsp_result_pixel;

   grayscale_morphology_window_top uut (.*);

   // bench copy of the filter state
   logic [7:0]  line_ring [RING * DEF_MAX_WIDTH];
   logic [18:0] tap_rows [TAPS];
   int          in_col, in_row, out_col, out_row;
   logic        cfg_mode;
   logic [10:0] cfg_width;
   logic [15:0] cfg_height;
   logic [3:0]  cfg_radius;
   logic        frame_closed;
   filtered_t   pending_pixels [$];

   int errors = 0, requests = 0, idle_cycles = 0;
   int snd_idle = 0, rcv_idle = 0;

   initial forever #10 clock = ~clock;

   function automatic int eff_w();
      if (cfg_width < 1) return 1;
      if (cfg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int eff_h();
      return (cfg_height < 1) ? 1 : cfg_height;
   endfunction

   function automatic int eff_r();
      return (cfg_radius > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : cfg_radius;
   endfunction

   function automatic logic [7:0] ring_pixel(int y, int x, int h, int w);
      if (y < 0) y = 0;
      if (y > h - 1) y = h - 1;
      if (x < 0) x = 0;
      if (x > w - 1) x = w - 1;
      return line_ring[(y % RING) * DEF_MAX_WIDTH + x];
   endfunction

   task automatic filter_window();
      int w, h, r;
      logic [7:0] acc, v;
      filtered_t f;
      w = eff_w(); h = eff_h(); r = eff_r();
      acc = cfg_mode ? PIX_MIN : PIX_MAX;
      for (int dy = -r; dy <= r; dy++)
         for (int dx = -r; dx <= r; dx++) begin
            if (tap_rows[dy + r][dx + r]) v = ring_pixel(out_row + dy, out_col + dx, h, w);
            else v = cfg_mode ? PIX_MIN : PIX_MAX;
            if (cfg_mode ? (v > acc) : (v < acc)) acc = v;
         end
      f.last = 0;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) begin
            f.last = 1;
            out_row = 0; in_row = 0; in_col = 0;
            frame_closed = 1;
         end
      end
      f.pix = acc;
      pending_pixels.push_back(f);
   endtask

   task automatic model_request(logic [1:0] op, logic [7:0] pix, logic [4:0] idx,
                                logic [18:0] bits);
      int w, h, r, need_r, need_c;
      w = eff_w(); h = eff_h(); r = eff_r();
      case (op)
         OP_MASK: if (idx < TAPS) tap_rows[idx] = bits;
         OP_FLUSH: if (in_row >= h) filter_window();
         OP_PIXEL: if (in_row < h) begin
            line_ring[(in_row % RING) * DEF_MAX_WIDTH + in_col] = pix;
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
            end
            need_r = (out_row + r > h - 1) ? h - 1 : out_row + r;
            need_c = (out_col + r > w - 1) ? w - 1 : out_col + r;
            if (in_row > need_r || (in_row == need_r && in_col > need_c)) filter_window();
         end
         default: ;
      endcase
   endtask

   task automatic send_request(logic [1:0] op, logic [7:0] pix, logic [4:0] idx,
                               logic [18:0] bits);
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 0;
         @(negedge clock);
         while ($urandom_range(99) < snd_idle) @(negedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_pixel_value <= pix;
      req_mask_row_index <= idx;
      req_mask_row_bits <= bits;
      do @(posedge clock); while (!req_ready);
      model_request(op, pix, idx, bits);
      requests++;
      @(negedge clock);
   endtask

   // sender holds off until every expected result is out and the block settles
   task automatic drain_block();
      req_valid <= 0;
      @(negedge clock);
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [15:0] data);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         REG_MODE: cfg_mode = data[0];
         REG_WIDTH: cfg_width = data[10:0];
         REG_HEIGHT: cfg_height = data;
         default: cfg_radius = data[3:0];
      endcase
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   task automatic setup_frame(logic md, int w, int h, int r);
      drain_block();
      write_reg(REG_MODE, 16'(md));
      write_reg(REG_WIDTH, 16'(w));
      write_reg(REG_HEIGHT, 16'(h));
      write_reg(REG_RADIUS, 16'(r));
   endtask

   // pixels of one frame, then flushes until the tail is out; noise in percent
   task automatic stream_frame(int noise, bit full_range_pix);
      logic [7:0] p;
      frame_closed = 0;
      for (int i = 0; i < eff_w() * eff_h(); i++) begin
         if ($urandom_range(99) < noise)
            case ($urandom_range(3))
               0: send_request(OP_FLUSH, 8'($urandom), 5'($urandom), 19'($urandom));
               1: send_request(OP_IGNORED, 8'($urandom), 5'($urandom), 19'($urandom));
               default: send_request(OP_MASK, 8'($urandom), 5'($urandom_range(31)),
                                     19'($urandom));
            endcase
         p = full_range_pix ? 8'($urandom) : ($urandom_range(1) ? 8'd0 : 8'd255);
         send_request(OP_PIXEL, p, 5'($urandom), 19'($urandom));
      end
      while (!frame_closed) begin
         if (in_row >= eff_h() && $urandom_range(99) < noise)
            send_request(OP_PIXEL, 8'($urandom), 5'($urandom), 19'($urandom));
         send_request(OP_FLUSH, 8'($urandom), 5'($urandom), 19'($urandom));
      end
   endtask

   task automatic test_mask_shapes();
      setup_frame(1'b0, 3, 3, 1);
      send_request(OP_MASK, 8'd0, 5'd0, 19'h00000);
      send_request(OP_MASK, 8'd0, 5'd1, 19'h7FFFF);
      send_request(OP_MASK, 8'd0, 5'd2, 19'h00005);
      send_request(OP_MASK, 8'd0, 5'd31, 19'h00000);
      send_request(OP_IGNORED, 8'hFF, 5'd31, 19'h7FFFF);
      stream_frame(0, 1'b0);
      setup_frame(1'b1, 3, 3, 1);
      stream_frame(0, 1'b1);
   endtask

   task automatic test_special_cases();
      setup_frame(1'b0, 2, 2, 1);
      frame_closed = 0;
      send_request(OP_FLUSH, 8'd0, 5'd0, 19'd0);
      repeat (4) send_request(OP_PIXEL, 8'($urandom), 5'd0, 19'd0);
      send_request(OP_PIXEL, 8'hFF, 5'd0, 19'd0);
      while (!frame_closed) send_request(OP_FLUSH, 8'd0, 5'd0, 19'd0);
      setup_frame(1'b1, 0, 0, 15);
      stream_frame(0, 1'b1);
   endtask

   task automatic test_register_extremes();
      for (int k = 0; k < TAPS; k++) send_request(OP_MASK, 8'd0, 5'(k), 19'($urandom));
      setup_frame(1'b0, 2, 3, 9);
      stream_frame(20, 1'b1);
      setup_frame(1'b1, 2047, 1, 0);
      stream_frame(0, 1'b1);
   endtask

   task automatic test_random_traffic(int s_idle, int r_idle, int quota);
      int stop_at, r;
      snd_idle = s_idle;
      rcv_idle = r_idle;
      stop_at = requests + quota;
      while (requests < stop_at) begin
         r = ($urandom_range(7) == 0) ? $urandom_range(9) : $urandom_range(2);
         setup_frame(1'($urandom_range(1)), $urandom_range(1, 10), $urandom_range(1, 5), r);
         if ($urandom_range(1))
            repeat ($urandom_range(1, 6))
               send_request(OP_MASK, 8'($urandom), 5'($urandom_range(2 * r)),
                            19'($urandom));
         stream_frame($urandom_range(3) == 0 ? 25 : 3, $urandom_range(3) != 0);
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= rcv_idle);

   always @(posedge clock) begin
      filtered_t f;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", rsp_result_pixel, -1);
         end else begin
            f = pending_pixels.pop_front();
            if (rsp_result_pixel !== f.pix) report_mismatch("pixel", rsp_result_pixel, f.pix);
            if (rsp_frame_last !== f.last)
               report_mismatch("frame_last", rsp_frame_last, f.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < TAPS; k++) tap_rows[k] = '1;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      cfg_mode = 1'b0; cfg_width = 11'd1024; cfg_height = 16'd1024; cfg_radius = 4'd9;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(negedge clock);
      test_mask_shapes();
      test_special_cases();
      test_register_extremes();
      test_random_traffic(28, 56, 60);
      test_random_traffic(56, 28, 60);
      test_random_traffic(0, 0, 60);
      drain_block();
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
